/* rtl/ptts_pkg.sv */
// package: shared types and constants of the periodic task table scheduler
package ptts_pkg;

  localparam int unsigned NumSlotsDefault = 8;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned HandleW = 16;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned SlotW   = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT   = 3'd0,
    MODE_DEINIT = 3'd1,
    MODE_CREATE = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_MODIFY = 3'd4,
    MODE_TICK   = 3'd5,
    MODE_RUN    = 3'd6
  } mode_e;

  // one stored slot row
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [DelayW-1:0]  delay;
    logic [PeriodW-1:0] period;
  } slot_row_t;

  // table update controls from the sequencer
  typedef struct packed {
    logic wr_en;
    logic set_vld;
    logic clr_vld;
    logic set_rdy;
    logic clr_rdy;
    logic clear_all;
  } tbl_op_t;

endpackage

/* rtl/ptts_slot_table.sv */
// slot table: row memory with per-slot occupied and ready flags
module ptts_slot_table #(
  parameter int unsigned NUM_SLOTS = ptts_pkg::NumSlotsDefault,
  parameter int unsigned SW        = $clog2(NUM_SLOTS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SW-1:0]       rd_addr_i,
  input  logic [SW-1:0]       wr_idx_i,
  input  ptts_pkg::slot_row_t wr_row_i,
  input  ptts_pkg::tbl_op_t   op_i,
  output ptts_pkg::slot_row_t rd_row_o,
  output logic                rd_vld_o,
  output logic                rd_rdy_o,
  output logic [NUM_SLOTS-1:0] vld_o
);

  ptts_pkg::slot_row_t mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q, vld_d;
  logic [NUM_SLOTS-1:0] rdy_q, rdy_d;

  always_ff @(posedge clk_i) begin
    if (op_i.wr_en) begin
      mem[wr_idx_i] <= wr_row_i;
    end
    rd_row_o <= mem[rd_addr_i];
  end

  always_comb begin
    vld_d = vld_q;
    rdy_d = rdy_q;
    if (op_i.set_vld) vld_d[wr_idx_i] = 1'b1;
    if (op_i.clr_vld) vld_d[wr_idx_i] = 1'b0;
    if (op_i.set_rdy) rdy_d[wr_idx_i] = 1'b1;
    if (op_i.clr_rdy) rdy_d[wr_idx_i] = 1'b0;
    if (op_i.clear_all) begin
      vld_d = '0;
      rdy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rdy_q    <= '0;
      rd_vld_o <= 1'b0;
      rd_rdy_o <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      rdy_q    <= rdy_d;
      rd_vld_o <= vld_q[rd_addr_i];
      rd_rdy_o <= rdy_q[rd_addr_i];
    end
  end

  assign vld_o = vld_q;

endmodule

/* rtl/periodic_task_table_scheduler.sv */
// top level: time-triggered cooperative scheduler over a table of task slots
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser: mode; tdata: handle, delay, period, slot
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: status, slot, dispatched, handle
//
// init, deinit, delete, tick and undefined modes, and create or modify with a null handle, go from accept
// straight to the finish state, which raises tvalid once the output register is free; otherwise create
// and modify walk the table one slot per cycle; run walks once for dispatch, and once more over all slots
// when a tick is pending; the single memory read port paces the walks
// reset clears the table at once through per-slot occupied flags, no clearing pass
// one command at a time; a finished result waits in the output register under stall
module periodic_task_table_scheduler #(
  parameter int unsigned NUM_SLOTS = ptts_pkg::NumSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // task_handle[15:0], delay[31:16], period[47:32],
                                       // slot_index[53:48], zero fill[55:54]
  input  logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // status[0], assigned_slot[6:1], dispatched[7],
                                       // dispatched_handle[23:8]
);

  localparam int unsigned SW   = $clog2(NUM_SLOTS);
  localparam int unsigned CntW = SW + 1;
  localparam logic [CntW-1:0]             NumSlotsC = CntW'(NUM_SLOTS);
  localparam logic [ptts_pkg::SlotW:0]    NumSlotsI = (ptts_pkg::SlotW + 1)'(NUM_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_WALK_CMD  = 4'b0010,
    ST_WALK_TICK = 4'b0100,
    ST_FINISH    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // input field unpacking
  ptts_pkg::mode_e                 in_mode;
  logic [ptts_pkg::HandleW-1:0]    in_handle;
  logic [ptts_pkg::DelayW-1:0]     in_delay;
  logic [ptts_pkg::PeriodW-1:0]    in_period;
  logic [ptts_pkg::SlotW-1:0]      in_slot;

  assign in_mode   = ptts_pkg::mode_e'(s_axis_tuser_i);
  assign in_handle = s_axis_tdata_i[15:0];
  assign in_delay  = s_axis_tdata_i[31:16];
  assign in_period = s_axis_tdata_i[47:32];
  assign in_slot   = s_axis_tdata_i[53:48];

  // latched command
  ptts_pkg::mode_e              cmd_mode_q, cmd_mode_d;
  logic [ptts_pkg::HandleW-1:0] cmd_handle_q, cmd_handle_d;
  logic [ptts_pkg::DelayW-1:0]  cmd_delay_q, cmd_delay_d;
  logic [ptts_pkg::PeriodW-1:0] cmd_period_q, cmd_period_d;

  // scheduler flags
  logic initialized_q, initialized_d;
  logic tick_pending_q, tick_pending_d;

  // walk sequencer: issue counter and the slot whose row arrives this cycle
  logic [CntW-1:0] iss_q, iss_d;
  logic            ev_vld_q, ev_vld_d;
  logic [SW-1:0]   ev_idx_q, ev_idx_d;

  // result under construction
  logic                         res_status_q, res_status_d;
  logic [ptts_pkg::SlotW-1:0]   res_slot_q, res_slot_d;
  logic                         res_disp_q, res_disp_d;
  logic [ptts_pkg::HandleW-1:0] res_handle_q, res_handle_d;

  // output register
  logic        out_vld_q, out_vld_d;
  logic [23:0] out_data_q, out_data_d;

  // table interface
  logic [SW-1:0]        rd_addr;
  logic [SW-1:0]        wr_idx;
  ptts_pkg::slot_row_t  wr_row;
  ptts_pkg::tbl_op_t    tbl_op;
  ptts_pkg::slot_row_t  rd_row;
  logic                 rd_vld;
  logic                 rd_rdy;
  logic [NUM_SLOTS-1:0] slot_vld;

  ptts_slot_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .SW       (SW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .wr_idx_i (wr_idx),
    .wr_row_i (wr_row),
    .op_i     (tbl_op),
    .rd_row_o (rd_row),
    .rd_vld_o (rd_vld),
    .rd_rdy_o (rd_rdy),
    .vld_o    (slot_vld)
  );

  logic accept;
  logic walk_end;
  logic found;
  logic del_ok;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign walk_end        = !ev_vld_q && (iss_q == NumSlotsC);
  assign del_ok          = ({1'b0, in_slot} < NumSlotsI) && slot_vld[in_slot[SW-1:0]];

  always_comb begin
    state_d        = state_q;
    cmd_mode_d     = cmd_mode_q;
    cmd_handle_d   = cmd_handle_q;
    cmd_delay_d    = cmd_delay_q;
    cmd_period_d   = cmd_period_q;
    initialized_d  = initialized_q;
    tick_pending_d = tick_pending_q;
    iss_d          = iss_q;
    ev_vld_d       = 1'b0;
    ev_idx_d       = ev_idx_q;
    res_status_d   = res_status_q;
    res_slot_d     = res_slot_q;
    res_disp_d     = res_disp_q;
    res_handle_d   = res_handle_q;
    out_vld_d      = out_vld_q && !m_axis_tready_i;
    out_data_d     = out_data_q;
    rd_addr        = iss_q[SW-1:0];
    wr_idx         = ev_idx_q;
    wr_row         = rd_row;
    tbl_op         = '0;
    found          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_mode_d   = in_mode;
          cmd_handle_d = in_handle;
          cmd_delay_d  = in_delay;
          cmd_period_d = in_period;
          res_status_d = 1'b0;
          res_slot_d   = '0;
          res_disp_d   = 1'b0;
          res_handle_d = '0;
          iss_d        = '0;
          state_d      = ST_FINISH;
          unique case (in_mode)
            ptts_pkg::MODE_INIT: begin
              if (initialized_q) begin
                res_status_d = 1'b1;
              end else begin
                tbl_op.clear_all = 1'b1;
                initialized_d    = 1'b1;
              end
            end
            ptts_pkg::MODE_DEINIT: begin
              if (initialized_q) begin
                tbl_op.clear_all = 1'b1;
                initialized_d    = 1'b0;
              end else begin
                res_status_d = 1'b1;
              end
            end
            ptts_pkg::MODE_CREATE,
            ptts_pkg::MODE_MODIFY: begin
              // refused up front on a null handle, else searched over the table
              res_status_d = 1'b1;
              if (in_handle != '0) state_d = ST_WALK_CMD;
            end
            ptts_pkg::MODE_DELETE: begin
              if (del_ok) begin
                wr_idx         = in_slot[SW-1:0];
                tbl_op.clr_vld = 1'b1;
                tbl_op.clr_rdy = 1'b1;
              end else begin
                res_status_d = 1'b1;
              end
            end
            ptts_pkg::MODE_TICK: begin
              tick_pending_d = 1'b1;
            end
            ptts_pkg::MODE_RUN: begin
              state_d = ST_WALK_CMD;
            end
            default: begin
              res_status_d = 1'b1;
            end
          endcase
        end
      end

      ST_WALK_CMD: begin
        // issue the next slot read while the previous row is evaluated
        if (iss_q < NumSlotsC) begin
          iss_d    = iss_q + CntW'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = iss_q[SW-1:0];
        end
        if (ev_vld_q) begin
          unique case (cmd_mode_q)
            ptts_pkg::MODE_CREATE: begin
              if (!rd_vld) begin
                found          = 1'b1;
                wr_row.handle  = cmd_handle_q;
                wr_row.delay   = cmd_delay_q;
                wr_row.period  = cmd_period_q;
                tbl_op.wr_en   = 1'b1;
                tbl_op.set_vld = 1'b1;
                tbl_op.clr_rdy = 1'b1;
                res_status_d   = 1'b0;
                res_slot_d     = ptts_pkg::SlotW'(ev_idx_q);
              end
            end
            ptts_pkg::MODE_MODIFY: begin
              if (rd_vld && (rd_row.handle == cmd_handle_q)) begin
                // ready flag of the slot is kept
                found         = 1'b1;
                wr_row.delay  = cmd_delay_q;
                wr_row.period = cmd_period_q;
                tbl_op.wr_en  = 1'b1;
                res_status_d  = 1'b0;
              end
            end
            default: begin
              // dispatch: lowest ready slot, one-shot tasks are freed
              if (rd_rdy) begin
                found          = 1'b1;
                res_disp_d     = 1'b1;
                res_handle_d   = rd_row.handle;
                tbl_op.clr_rdy = 1'b1;
                tbl_op.clr_vld = (rd_row.period == '0);
              end
            end
          endcase
        end
        if (found || walk_end) begin
          iss_d    = '0;
          ev_vld_d = 1'b0;
          if ((cmd_mode_q == ptts_pkg::MODE_RUN) && tick_pending_q) begin
            tick_pending_d = 1'b0;
            state_d        = ST_WALK_TICK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_WALK_TICK: begin
        // every occupied slot counts down, or turns ready and, if periodic, reloads
        if (iss_q < NumSlotsC) begin
          iss_d    = iss_q + CntW'(1);
          ev_vld_d = 1'b1;
          ev_idx_d = iss_q[SW-1:0];
        end
        if (ev_vld_q && rd_vld) begin
          if (rd_row.delay == '0) begin
            tbl_op.set_rdy = 1'b1;
            if (rd_row.period != '0) begin
              wr_row.delay = rd_row.period;
              tbl_op.wr_en = 1'b1;
            end
          end else begin
            wr_row.delay = rd_row.delay - ptts_pkg::DelayW'(1);
            tbl_op.wr_en = 1'b1;
          end
        end
        if (walk_end) state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // hand the result over once the output register is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = {res_handle_q, res_disp_q, res_slot_q, res_status_q};
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      initialized_q  <= 1'b0;
      tick_pending_q <= 1'b0;
      iss_q          <= '0;
      ev_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      initialized_q  <= initialized_d;
      tick_pending_q <= tick_pending_d;
      iss_q          <= iss_d;
      ev_vld_q       <= ev_vld_d;
      out_vld_q      <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_mode_q   <= cmd_mode_d;
    cmd_handle_q <= cmd_handle_d;
    cmd_delay_q  <= cmd_delay_d;
    cmd_period_q <= cmd_period_d;
    ev_idx_q     <= ev_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_disp_q   <= res_disp_d;
    res_handle_q <= res_handle_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* dv/ptts_sched_checker.sv */
// checker: predicts every scheduler result from accepted commands and compares it
module ptts_sched_checker #(
  parameter int unsigned NUM_SLOTS = ptts_pkg::NumSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,  // task_handle[15:0], delay[31:16], period[47:32],
                                       // slot_index[53:48], zero fill[55:54]
  input  logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,  // status[0], assigned_slot[6:1], dispatched[7],
                                       // dispatched_handle[23:8]
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o
);

  // highest field first so the layout matches the result bus
  typedef struct packed {
    logic [ptts_pkg::HandleW-1:0] disp_handle;
    logic                         disp;
    logic [ptts_pkg::SlotW-1:0]   slot;
    logic                         status;
  } sched_result_t;

  // shadow copy of the task table
  logic [ptts_pkg::HandleW-1:0] tbl_handle [NUM_SLOTS];
  logic [ptts_pkg::DelayW-1:0]  tbl_delay  [NUM_SLOTS];
  logic [ptts_pkg::PeriodW-1:0] tbl_period [NUM_SLOTS];
  logic                         tbl_ready  [NUM_SLOTS];
  logic                         tick_flag;
  logic                         sched_on;

  sched_result_t due_results[$];
  sched_result_t predicted;
  sched_result_t observed;
  int unsigned   mismatch_cnt;
  int unsigned   pending_cnt;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_cnt_o  = pending_cnt;

  task automatic flag_mismatch(input string what, input logic [23:0] got,
                               input logic [23:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_cnt++;
  endtask

  task automatic free_slot(input int s);
    tbl_handle[s] = '0;
    tbl_delay[s]  = '0;
    tbl_period[s] = '0;
    tbl_ready[s]  = 1'b0;
  endtask

  task automatic clear_table();
    for (int s = 0; s < NUM_SLOTS; s++) free_slot(s);
  endtask

  task automatic apply_command(input logic [ptts_pkg::ModeW-1:0] mode,
                               input logic [55:0] data, output sched_result_t res);
    logic [ptts_pkg::HandleW-1:0] hnd;
    logic [ptts_pkg::DelayW-1:0]  dly;
    logic [ptts_pkg::PeriodW-1:0] per;
    logic [ptts_pkg::SlotW-1:0]   idx;
    logic                         found;
    int                           si;
    hnd   = data[15:0];
    dly   = data[31:16];
    per   = data[47:32];
    idx   = data[53:48];
    si    = int'(idx);
    found = 1'b0;
    res   = '0;
    case (mode)
      ptts_pkg::MODE_INIT: begin
        if (sched_on) begin
          res.status = 1'b1;
        end else begin
          clear_table();
          sched_on = 1'b1;
        end
      end
      ptts_pkg::MODE_DEINIT: begin
        if (sched_on) begin
          clear_table();
          sched_on = 1'b0;
        end else begin
          res.status = 1'b1;
        end
      end
      ptts_pkg::MODE_CREATE: begin
        res.status = 1'b1;
        if (hnd != '0) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!found && tbl_handle[s] == '0) begin
              found         = 1'b1;
              tbl_handle[s] = hnd;
              tbl_delay[s]  = dly;
              tbl_period[s] = per;
              tbl_ready[s]  = 1'b0;
              res.slot      = s[ptts_pkg::SlotW-1:0];
              res.status    = 1'b0;
            end
          end
        end
      end
      ptts_pkg::MODE_DELETE: begin
        res.status = 1'b1;
        // bound first: indexes past the table must not touch it
        if (si < NUM_SLOTS) begin
          if (tbl_handle[si] != '0) begin
            free_slot(si);
            res.status = 1'b0;
          end
        end
      end
      ptts_pkg::MODE_MODIFY: begin
        res.status = 1'b1;
        if (hnd != '0) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!found && tbl_handle[s] == hnd) begin
              found         = 1'b1;
              tbl_delay[s]  = dly;
              tbl_period[s] = per;
              res.status    = 1'b0;
            end
          end
        end
      end
      ptts_pkg::MODE_TICK: begin
        tick_flag = 1'b1;
      end
      ptts_pkg::MODE_RUN: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!found && tbl_ready[s]) begin
            found           = 1'b1;
            res.disp        = 1'b1;
            res.disp_handle = tbl_handle[s];
            tbl_ready[s]    = 1'b0;
            if (tbl_period[s] == '0) free_slot(s);
          end
        end
        if (tick_flag) begin
          tick_flag = 1'b0;
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (tbl_handle[s] != '0) begin
              if (tbl_delay[s] == '0) begin
                tbl_ready[s] = 1'b1;
                if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
              end else begin
                tbl_delay[s] = tbl_delay[s] - ptts_pkg::DelayW'(1);
              end
            end
          end
        end
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      tick_flag    = 1'b0;
      sched_on     = 1'b0;
      mismatch_cnt = 0;
      pending_cnt  = 0;
      due_results.delete();
    end else begin
      // results first: nothing accepted at this edge can be answered at it
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        observed = m_axis_tdata_i;
        if (due_results.size() == 0) begin
          flag_mismatch("result with no command outstanding", m_axis_tdata_i, '0);
        end else begin
          predicted = due_results.pop_front();
          if (observed.status !== predicted.status)
            flag_mismatch("status", 24'(observed.status), 24'(predicted.status));
          if (observed.slot !== predicted.slot)
            flag_mismatch("assigned_slot", 24'(observed.slot), 24'(predicted.slot));
          if (observed.disp !== predicted.disp)
            flag_mismatch("dispatched", 24'(observed.disp), 24'(predicted.disp));
          if (observed.disp_handle !== predicted.disp_handle)
            flag_mismatch("dispatched_handle", 24'(observed.disp_handle),
                          24'(predicted.disp_handle));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_command(s_axis_tuser_i, s_axis_tdata_i, predicted);
        due_results.push_back(predicted);
      end
      pending_cnt = due_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// testbench top: drives scheduler commands, stalls the result side and gives the verdict
module tb_top;

  localparam int unsigned NumSlots = ptts_pkg::NumSlotsDefault;
  // mode code the block does not define
  localparam logic [ptts_pkg::ModeW-1:0] ModeUndef = 3'd7;
  // no transaction on either side for this many cycles means the block hung
  localparam int unsigned IdleLimit = 500;
  // longest command: two table walks plus overhead
  localparam int unsigned DrainCycles = 2 * NumSlots + 10;
  localparam int unsigned RandomItems = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // task_handle[15:0], delay[31:16], period[47:32],
                                   // slot_index[53:48], zero fill[55:54]
  logic [2:0]  s_axis_tuser = '0;  // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // status[0], assigned_slot[6:1], dispatched[7],
                                   // dispatched_handle[23:8]

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned idle_cycles = 0;

  // 20 unit period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  periodic_task_table_scheduler #(
    .NUM_SLOTS(NumSlots)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  ptts_sched_checker #(
    .NUM_SLOTS(NumSlots)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // result side back-pressure: ready runs of random length broken by stalls,
  // though a quarter of the runs are followed by no stall at all
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (ready_left > 0) begin
        ready_left--;
      end else begin
        ready_left = $urandom_range(1, 20);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("periodic_task_table_scheduler verification failed");
        $finish;
      end
    end
  end

  // present one command at the falling edge and hold it until accepted;
  // returns at a falling edge so the next command can follow without a gap
  task automatic issue(input logic [ptts_pkg::ModeW-1:0] mode,
                       input logic [ptts_pkg::HandleW-1:0] hnd,
                       input logic [ptts_pkg::DelayW-1:0] dly,
                       input logic [ptts_pkg::PeriodW-1:0] per,
                       input logic [ptts_pkg::SlotW-1:0] idx);
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, idx, per, dly, hnd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // handles mostly from a small pool so modify hits and duplicates occur
  function automatic logic [ptts_pkg::HandleW-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return ptts_pkg::HandleW'($urandom_range(1, 12));
    if (r < 80) return '0;
    return ptts_pkg::HandleW'($urandom);
  endfunction

  // short delays so tasks get released, some large ones for the upper bits
  function automatic logic [ptts_pkg::DelayW-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return ptts_pkg::DelayW'($urandom_range(0, 4));
    if (r < 85) return {ptts_pkg::DelayW{1'b1}};
    return ptts_pkg::DelayW'($urandom);
  endfunction

  function automatic logic [ptts_pkg::PeriodW-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 75) return ptts_pkg::PeriodW'($urandom_range(1, 4));
    if (r < 82) return {ptts_pkg::PeriodW{1'b1}};
    return ptts_pkg::PeriodW'($urandom);
  endfunction

  initial begin
    logic [ptts_pkg::ModeW-1:0]   mode;
    logic [ptts_pkg::HandleW-1:0] hnd;
    logic [ptts_pkg::DelayW-1:0]  dly;
    logic [ptts_pkg::PeriodW-1:0] per;
    logic [ptts_pkg::SlotW-1:0]   idx;
    int unsigned                  pick;
    int unsigned                  burst_left;
    int unsigned                  gap;

    burst_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // deinit before init is refused, then init, then a second init is refused
    issue(ptts_pkg::MODE_DEINIT, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_INIT, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_INIT, 16'h0, 16'h0, 16'h0, 6'd0);
    // create with the null handle is refused
    issue(ptts_pkg::MODE_CREATE, 16'h0, 16'h1, 16'h1, 6'd0);
    // fill the table: slot 0 one-shot due at once, slot 1 with all-ones delay and period,
    // slots 6 and 7 share a handle for the lowest-match rule of modify
    for (int i = 0; i < NumSlots; i++) begin
      if (i == 0) begin
        issue(ptts_pkg::MODE_CREATE, 16'hFFFF, 16'h0, 16'h0, 6'd0);
      end else if (i == 1) begin
        issue(ptts_pkg::MODE_CREATE, 16'h0001, 16'hFFFF, 16'hFFFF, 6'd0);
      end else begin
        issue(ptts_pkg::MODE_CREATE, (i >= 6) ? 16'h0106 : 16'h0100 + i[15:0],
              16'(i - 2), 16'(i), 6'd0);
      end
    end
    // table full
    issue(ptts_pkg::MODE_CREATE, 16'h4321, 16'h0, 16'h0, 6'd0);
    // tick then run releases slots; second run dispatches the one-shot and frees it,
    // third run has no tick pending and dispatches a periodic task
    issue(ptts_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_RUN, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_RUN, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_RUN, 16'h0, 16'h0, 16'h0, 6'd0);
    // delete past the table at the top of the field and at the bound,
    // of the slot just freed, and of an occupied slot
    issue(ptts_pkg::MODE_DELETE, 16'h0, 16'h0, 16'h0, 6'd63);
    issue(ptts_pkg::MODE_DELETE, 16'h0, 16'h0, 16'h0, ptts_pkg::SlotW'(NumSlots));
    issue(ptts_pkg::MODE_DELETE, 16'h0, 16'h0, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_DELETE, 16'h0, 16'h0, 16'h0, 6'd1);
    // modify: null handle, unknown handle, duplicated handle
    issue(ptts_pkg::MODE_MODIFY, 16'h0, 16'h5, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_MODIFY, 16'h7777, 16'h5, 16'h0, 6'd0);
    issue(ptts_pkg::MODE_MODIFY, 16'h0106, 16'h5, 16'h0, 6'd0);
    issue(ModeUndef, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
    issue(ptts_pkg::MODE_DEINIT, 16'h0, 16'h0, 16'h0, 6'd0);

    // ---- random part ----
    for (int n = 0; n < RandomItems; n++) begin
      // halfway the sender holds off until the block has answered everything
      if (n == RandomItems / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending_cnt != 0) @(negedge clk_i);
      end

      // every field random first, then shaped for the chosen mode
      hnd  = ptts_pkg::HandleW'($urandom);
      dly  = ptts_pkg::DelayW'($urandom);
      per  = ptts_pkg::PeriodW'($urandom);
      idx  = ptts_pkg::SlotW'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        mode = ptts_pkg::MODE_INIT;
      end else if (pick < 6) begin
        mode = ptts_pkg::MODE_DEINIT;
      end else if (pick < 8) begin
        mode = ModeUndef;
      end else if (pick < 30) begin
        mode = ptts_pkg::MODE_CREATE;
        hnd  = pick_handle();
        dly  = pick_delay();
        per  = pick_period();
      end else if (pick < 40) begin
        mode = ptts_pkg::MODE_DELETE;
        if ($urandom_range(0, 4) != 0) begin
          idx = ptts_pkg::SlotW'($urandom_range(0, NumSlots - 1));
        end
      end else if (pick < 50) begin
        mode = ptts_pkg::MODE_MODIFY;
        hnd  = pick_handle();
        dly  = pick_delay();
        per  = pick_period();
      end else if (pick < 70) begin
        mode = ptts_pkg::MODE_TICK;
      end else begin
        mode = ptts_pkg::MODE_RUN;
      end

      // bursts of random length with gaps in between, sometimes a long burst
      gap = 0;
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 10);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      idle_for(gap);
      issue(mode, hnd, dly, per, idx);
    end

    // ---- drain ----
    s_axis_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("periodic_task_table_scheduler verification clean");
    end else begin
      $display("periodic_task_table_scheduler verification failed");
    end
    $finish;
  end

endmodule
